// File: design/lpss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpss_pkg: shared types and constants of the LED panel scan serializer
// Frame geometry, chain geometry, opcodes and the word layouts of both channels.
// ----------------------------------------------------------------------------
package lpss_pkg;

  localparam int unsigned FRAME_DIM    = 88;
  localparam int unsigned FRAME_DEPTH  = FRAME_DIM * FRAME_DIM;
  localparam int unsigned ADDR_W       = $clog2(FRAME_DEPTH);
  localparam int unsigned COORD_W      = 7;
  localparam int unsigned LEVEL_W      = 16;
  localparam int unsigned PIXEL_W      = 3 * LEVEL_W;
  localparam int unsigned CHIPS        = 22;
  localparam int unsigned HALF_CHIPS   = 11;
  localparam int unsigned CHIP_W       = 5;
  localparam int unsigned SLOTS        = 16;
  localparam int unsigned SLOT_W       = 4;
  localparam int unsigned UPPER_OFFSET = 11;
  localparam int unsigned LINE_SPAN    = 22;
  localparam int unsigned FIRST_OFFSET = 66;
  localparam int unsigned SHIFT_W      = 4;

  localparam int unsigned SCAN_LINES_DEF = 11;
  localparam int unsigned GRAY_BITS_DEF  = 16;

  typedef enum logic [0:0] {
    OP_TICK  = 1'b0,
    OP_WRITE = 1'b1
  } lpss_op_t;

  typedef struct packed {
    logic [0:0]         opcode;
    logic [COORD_W-1:0] pixel_row;
    logic [COORD_W-1:0] pixel_col;
    logic [LEVEL_W-1:0] red_level;
    logic [LEVEL_W-1:0] green_level;
    logic [LEVEL_W-1:0] blue_level;
  } cmd_word_t;

  typedef struct packed {
    logic red_first;
    logic green_first;
    logic blue_first;
    logic red_second;
    logic green_second;
    logic blue_second;
    logic latch_enable;
    logic frame_end;
  } bits_word_t;

endpackage

// File: design/lpss_cmd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpss_cmd_if: command channel
// Carries tick and pixel-write words with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface lpss_cmd_if import lpss_pkg::*; ();
  logic      valid;
  logic      ready;
  cmd_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: design/lpss_bits_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpss_bits_if: serial bit channel
// Carries one shift-clock word of data bits and latch flags per handshake.
// ----------------------------------------------------------------------------
interface lpss_bits_if import lpss_pkg::*; ();
  logic       valid;
  logic       ready;
  bits_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: design/led_panel_scan_serializer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_panel_scan_serializer_top: 88x88 frame store and driver-chain serializer
//
// Channels: cmd takes one word per handshake. A write word (opcode OP_WRITE)
// stores the 48-bit RGB pixel at pixel_row/pixel_col; coordinates above 87
// are dropped. A tick word (opcode OP_TICK) produces exactly one word on
// bits: six data bits (upper/lower pixel RGB, MSB first per chip), plus
// latch_enable on the last bit of each 22-chip chain pass and frame_end on
// the last bit of the whole scan.
// Path: a tick word reaches bits through the synchronous frame memory read
// and then the output register.
// Throughput: one word per cycle while not stalled, ticks and writes mixed freely;
// both reads of a tick use the two read ports of the frame memory in the same cycle.
// Reset: rst clears the scan counters and starts a clearing pass that zeroes
// the frame memory one pixel a cycle; cmd.ready stays low until the pass
// reaches the last address.
// Stall: when bits.ready is low the output register holds its word, the
// read stage holds one more, and cmd.ready drops once both hold words, until the output drains.
// ----------------------------------------------------------------------------
module led_panel_scan_serializer_top
  import lpss_pkg::*;
#(
  parameter int unsigned SCAN_LINES = SCAN_LINES_DEF,
  parameter int unsigned GRAY_BITS  = GRAY_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  lpss_cmd_if.sink           cmd,
  lpss_bits_if.source        bits
);

  localparam int unsigned ROW_W = (SCAN_LINES > 1) ? $clog2(SCAN_LINES) : 1;
  localparam int unsigned BIT_W = $clog2(GRAY_BITS);
  localparam logic [ROW_W-1:0]   ROW_LAST  = ROW_W'(SCAN_LINES - 1);
  localparam logic [BIT_W-1:0]   BIT_TOP   = BIT_W'(GRAY_BITS - 1);
  localparam logic [SHIFT_W-1:0] SHIFT_OFF = SHIFT_W'(LEVEL_W - GRAY_BITS);
  localparam logic [ADDR_W-1:0]  ADDR_LAST = ADDR_W'(FRAME_DEPTH - 1);

  // Frame memory: one write port, two registered read ports.
  logic [PIXEL_W-1:0] frame_mem [FRAME_DEPTH];

  // Clearing pass after reset.
  logic              clearing;
  logic [ADDR_W-1:0] clr_addr;

  // Scan position.
  logic [ROW_W-1:0]  scan_row, scan_row_next;
  logic [SLOT_W-1:0] led_slot, led_slot_next;
  logic [CHIP_W-1:0] chip_index, chip_index_next;
  logic [BIT_W-1:0]  bit_index, bit_index_next;

  // Handshake and stage control.
  logic cmd_fire, tick_fire, write_fire, write_in_range;
  logic s1_valid, s1_adv, out_valid;

  // Address generation for a tick.
  logic               chip_upper;
  logic [SLOT_W-1:0]  chip_mod;
  logic [COORD_W-1:0] base_row, first_row, second_row, scan_col;
  logic [ADDR_W-1:0]  first_addr, second_addr, write_addr;
  logic               latch_now, frame_end_now;

  // Memory port signals.
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [PIXEL_W-1:0] mem_wdata;

  // Read stage.
  logic [PIXEL_W-1:0] rd_first, rd_second;
  logic               s1_first_off, s1_second_off, s1_latch, s1_frame_end;
  logic [SHIFT_W-1:0] s1_shift;
  bits_word_t         s1_word, out_word;

  // Handshake: a tick may enter when the read stage is free or moving on.
  assign s1_adv     = !out_valid || bits.ready;
  assign cmd.ready  = !clearing && (!s1_valid || s1_adv);
  assign cmd_fire   = cmd.valid && cmd.ready;
  assign tick_fire  = cmd_fire && (cmd.data.opcode == OP_TICK);
  assign write_fire = cmd_fire && (cmd.data.opcode == OP_WRITE);

  assign write_in_range = (cmd.data.pixel_row < COORD_W'(FRAME_DIM)) &&
                          (cmd.data.pixel_col < COORD_W'(FRAME_DIM));

  // Map the scan position to the two pixels of this shift clock.
  // Slots 0..7 sit 11 rows lower and read columns mirrored within 8.
  always_comb begin
    chip_upper = chip_index >= CHIP_W'(HALF_CHIPS);
    chip_mod   = chip_upper ? SLOT_W'(chip_index - CHIP_W'(HALF_CHIPS))
                            : SLOT_W'(chip_index);
    base_row   = COORD_W'(scan_row) +
                 (led_slot[3] ? '0 : COORD_W'(UPPER_OFFSET));
    first_row  = base_row + (chip_upper ? COORD_W'(FIRST_OFFSET - LINE_SPAN)
                                        : COORD_W'(FIRST_OFFSET));
    second_row = base_row + (chip_upper ? '0 : COORD_W'(LINE_SPAN));
    scan_col   = {chip_mod, (led_slot[3] ? led_slot[2:0] : ~led_slot[2:0])};
    first_addr  = ADDR_W'(first_row) * ADDR_W'(FRAME_DIM) + ADDR_W'(scan_col);
    second_addr = ADDR_W'(second_row) * ADDR_W'(FRAME_DIM) + ADDR_W'(scan_col);
    write_addr  = ADDR_W'(cmd.data.pixel_row) * ADDR_W'(FRAME_DIM) +
                  ADDR_W'(cmd.data.pixel_col);
    latch_now     = (chip_index == CHIP_W'(CHIPS - 1)) && (bit_index == '0);
    frame_end_now = latch_now && (led_slot == SLOT_W'(SLOTS - 1)) &&
                    (scan_row == ROW_LAST);
  end

  // Advance the scan: bit, then chip, then slot, then scanline.
  always_comb begin
    scan_row_next   = scan_row;
    led_slot_next   = led_slot;
    chip_index_next = chip_index;
    bit_index_next  = bit_index;
    if (tick_fire) begin
      if (bit_index != '0) begin
        bit_index_next = bit_index - BIT_W'(1);
      end else begin
        bit_index_next = BIT_TOP;
        if (chip_index != CHIP_W'(CHIPS - 1)) begin
          chip_index_next = chip_index + CHIP_W'(1);
        end else begin
          chip_index_next = '0;
          led_slot_next   = led_slot + SLOT_W'(1);
          if (led_slot == SLOT_W'(SLOTS - 1)) begin
            scan_row_next = (scan_row == ROW_LAST) ? '0 : scan_row + ROW_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_row   <= '0;
      led_slot   <= '0;
      chip_index <= '0;
      bit_index  <= BIT_TOP;
    end else begin
      scan_row   <= scan_row_next;
      led_slot   <= led_slot_next;
      chip_index <= chip_index_next;
      bit_index  <= bit_index_next;
    end
  end

  // Clearing pass: zero one pixel a cycle until the last address.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + ADDR_W'(1);
      if (clr_addr == ADDR_LAST) begin
        clearing <= 1'b0;
      end
    end
  end

  assign mem_we    = clearing || (write_fire && write_in_range);
  assign mem_waddr = clearing ? clr_addr : write_addr;
  assign mem_wdata = clearing ? '0 : {cmd.data.red_level, cmd.data.green_level,
                                      cmd.data.blue_level};

  // Writes and tick reads never share an edge, and a write lands before any
  // later tick samples the memory, so no forwarding is needed.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_mem[mem_waddr] <= mem_wdata;
    end
    if (tick_fire) begin
      rd_first  <= frame_mem[first_addr];
      rd_second <= frame_mem[second_addr];
    end
  end

  // Read stage payload: rows past the frame read as zero.
  always_ff @(posedge clk) begin
    if (tick_fire) begin
      s1_first_off  <= first_row >= COORD_W'(FRAME_DIM);
      s1_second_off <= second_row >= COORD_W'(FRAME_DIM);
      s1_shift      <= SHIFT_OFF + SHIFT_W'(bit_index);
      s1_latch      <= latch_now;
      s1_frame_end  <= frame_end_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (tick_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  // Pick the current bit of each level; layout is {red, green, blue}.
  always_comb begin
    s1_word.red_first    = !s1_first_off  && rd_first[2*LEVEL_W + s1_shift];
    s1_word.green_first  = !s1_first_off  && rd_first[LEVEL_W + s1_shift];
    s1_word.blue_first   = !s1_first_off  && rd_first[s1_shift];
    s1_word.red_second   = !s1_second_off && rd_second[2*LEVEL_W + s1_shift];
    s1_word.green_second = !s1_second_off && rd_second[LEVEL_W + s1_shift];
    s1_word.blue_second  = !s1_second_off && rd_second[s1_shift];
    s1_word.latch_enable = s1_latch;
    s1_word.frame_end    = s1_frame_end;
  end

  // Output register: hold while the receiver stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid) begin
      out_word <= s1_word;
    end
  end

  assign bits.valid = out_valid;
  assign bits.data  = out_word;

endmodule

// File: design/lpss_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpss_checker: port-level checks of the scan serializer
// Watches both channels and the reset behavior from the top-level ports.
// ----------------------------------------------------------------------------
module lpss_checker
  import lpss_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       cmd_ready,
  input logic       bits_valid,
  input logic       bits_ready,
  input bits_word_t bits_data
);

  // Hold a stalled word on the bit channel.
  a_bits_hold: assert property (@(posedge clk) disable iff (rst)
    bits_valid && !bits_ready |=> bits_valid && $stable(bits_data))
    else $error("bits word changed while stalled");

  // Keep cmd.ready low right after reset, as the clearing pass begins.
  a_clear_blocks: assert property (@(posedge clk)
    rst |=> !cmd_ready)
    else $error("command accepted during clearing pass");

  // Flush the pipeline on reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !bits_valid)
    else $error("bits word shown right after reset");

  // Mark frame end only on a chain-pass latch.
  a_frame_end_latch: assert property (@(posedge clk) disable iff (rst)
    bits_valid && bits_data.frame_end |-> bits_data.latch_enable)
    else $error("frame_end without latch_enable");

endmodule

bind led_panel_scan_serializer_top lpss_checker u_lpss_checker (
  .clk        (clk),
  .rst        (rst),
  .cmd_ready  (cmd.ready),
  .bits_valid (bits.valid),
  .bits_ready (bits.ready),
  .bits_data  (bits.data)
);
